// ===== hw/rtl/dps_pkg.sv =====
// Shared types, constants and codes for the dynamic priority scheduler.
package dps_pkg;

    // Default queue depth
    localparam int DPS_QUEUE_DEPTH = 16;

    // Field widths
    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 3;

    // Request types
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SLICE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_RUN = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RAN      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd4;

    // Lowest priority; decrement saturates here
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = 8'sh80;

    // One queued process
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [TIME_W-1:0]        arrival;
        logic [TIME_W-1:0]        remaining;
    } entry_t;

    // Chain-wide operation
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    // Broadcast to every cell
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_REINSERT
    } state_t;

endpackage

// ===== hw/rtl/dps_req_if.sv =====
// Request channel: valid/ready handshake carrying add and time-slice requests.
interface dps_req_if
    import dps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [ID_W-1:0]          proc_id;
    logic signed [PRIO_W-1:0] priority_req;
    logic [TIME_W-1:0]        arrival_time;
    logic [TIME_W-1:0]        run_time;

    modport source (
        output valid, req_type, proc_id, priority_req, arrival_time, run_time,
        input  ready
    );

    modport sink (
        input  valid, req_type, proc_id, priority_req, arrival_time, run_time,
        output ready
    );
endinterface

// ===== hw/rtl/dps_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result per request.
interface dps_rsp_if
    import dps_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [ID_W-1:0]          ran_id;
    logic                     finished;
    logic [TIME_W-1:0]        remaining_after;
    logic signed [PRIO_W-1:0] priority_after;

    modport source (
        output valid, status, ran_id, finished, remaining_after, priority_after,
        input  ready
    );

    modport sink (
        input  valid, status, ran_id, finished, remaining_after, priority_after,
        output ready
    );
endinterface

// ===== hw/rtl/dps_cell.sv =====
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module dps_cell
    import dps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      left_valid,
    input  logic      left_before,
    input  entry_t    left_entry,
    input  logic      right_valid,
    input  entry_t    right_entry,
    output logic      valid,
    output logic      ahead,
    output entry_t    entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   ins_here;

    // Newcomer ranks strictly ahead of this entry
    assign ahead = valid_reg &&
                   ((cmd.new_entry.prio > entry_reg.prio) ||
                    ((cmd.new_entry.prio == entry_reg.prio) &&
                     (cmd.new_entry.arrival < entry_reg.arrival)));

    // Slot lies at or past the insertion point
    assign ins_here = !valid_reg || ahead;

    // Next slot contents
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (left_before)
                begin
                    valid_next = 1'b1;
                    entry_next = left_entry;
                end
                else if (ins_here && left_valid)
                begin
                    valid_next = 1'b1;
                    entry_next = cmd.new_entry;
                end
            end
            OP_POP:
            begin
                valid_next = right_valid;
                entry_next = right_entry;
            end
            default:
            begin
                valid_next = valid_reg;
                entry_next = entry_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== hw/rtl/dynamic_priority_scheduler_unit.sv =====
// Dynamic priority scheduler with aging: top level with controller and cell chain.
//
// A ready queue of up to QUEUE_DEPTH processes held in a chain of cells, sorted by
// descending priority, then ascending arrival time, then insertion order; cell 0
// is the head. An add request is inserted (or rejected for zero run time or a
// full queue) in the cycle it is accepted, by a broadcast compare in every cell
// and a one-slot shift. A time-slice request pops the head in the cycle it is
// accepted (on an empty queue it returns an idle status) and its result is
// registered then; an unfinished process is put back through the chain in the
// following cycle, while no new request is taken. No clearing pass is needed
// after reset. A new request is taken while the controller is idle and the
// result register is empty or being emptied in the same cycle.
module dynamic_priority_scheduler_unit
    import dps_pkg::*;
#(
    parameter int QUEUE_DEPTH = DPS_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    dps_req_if.sink      req,
    dps_rsp_if.source    rsp
);

    state_t    state_reg;
    state_t    state_next;
    cell_cmd_t cmd;
    entry_t    hold_reg;
    entry_t    hold_next;
    logic      hold_load;

    logic      req_fire;
    logic      queue_empty;
    logic      queue_full;

    // Head after one slice
    entry_t    head_dec;
    logic      head_done;

    // Result register
    logic                     rsp_valid_reg;
    logic                     rsp_load;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic [ID_W-1:0]          ran_id_reg;
    logic [ID_W-1:0]          ran_id_next;
    logic                     finished_reg;
    logic                     finished_next;
    logic [TIME_W-1:0]        remaining_reg;
    logic [TIME_W-1:0]        remaining_next;
    logic signed [PRIO_W-1:0] prio_out_reg;
    logic signed [PRIO_W-1:0] prio_out_next;

    // Chain wiring; the extra slot past the tail reads as empty
    logic   cell_valid  [0:QUEUE_DEPTH];
    logic   cell_before [0:QUEUE_DEPTH];
    entry_t cell_entry  [0:QUEUE_DEPTH];

    assign cell_valid[QUEUE_DEPTH]  = 1'b0;
    assign cell_before[QUEUE_DEPTH] = 1'b0;
    assign cell_entry[QUEUE_DEPTH]  = '0;

    // Cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   lv;
        logic   lb;
        entry_t le;

        if (i == 0)
        begin : g_head
            assign lv = 1'b1;
            assign lb = 1'b0;
            assign le = '0;
        end
        else
        begin : g_body
            assign lv = cell_valid[i-1];
            assign lb = cell_before[i-1];
            assign le = cell_entry[i-1];
        end

        dps_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_valid  (lv),
            .left_before (lb),
            .left_entry  (le),
            .right_valid (cell_valid[i+1]),
            .right_entry (cell_entry[i+1]),
            .valid       (cell_valid[i]),
            .ahead       (cell_before[i]),
            .entry       (cell_entry[i])
        );
    end

    assign queue_empty = !cell_valid[0];
    assign queue_full  = cell_valid[QUEUE_DEPTH-1];
    assign req_fire    = req.valid && req.ready;

    // Aging of the head process
    always_comb
    begin
        head_dec = cell_entry[0];
        if (cell_entry[0].prio != PRIO_MIN)
            head_dec.prio = cell_entry[0].prio - 8'sd1;
        if (cell_entry[0].remaining != '0)
            head_dec.remaining = cell_entry[0].remaining - 16'd1;
        head_done = (head_dec.remaining == '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_SLICE) && !queue_empty && !head_done)
                    state_next = ST_REINSERT;
            end
            ST_REINSERT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Controller outputs: handshake, chain command, result
    always_comb
    begin
        req.ready      = 1'b0;
        cmd.op         = OP_HOLD;
        cmd.new_entry  = hold_reg;
        hold_load      = 1'b0;
        hold_next      = head_dec;
        rsp_load       = 1'b0;
        status_next    = STAT_IDLE;
        ran_id_next    = '0;
        finished_next  = 1'b0;
        remaining_next = '0;
        prio_out_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = !rsp_valid_reg || rsp.ready;
                if (req_fire)
                begin
                    rsp_load = 1'b1;
                    if (req.req_type == REQ_ADD)
                    begin
                        cmd.new_entry.id        = req.proc_id;
                        cmd.new_entry.prio      = req.priority_req;
                        cmd.new_entry.arrival   = req.arrival_time;
                        cmd.new_entry.remaining = req.run_time;
                        if (req.run_time == '0)
                            status_next = STAT_ZERO_RUN;
                        else if (queue_full)
                            status_next = STAT_FULL;
                        else
                        begin
                            status_next = STAT_ADDED;
                            cmd.op      = OP_INSERT;
                        end
                    end
                    else if (!queue_empty)
                    begin
                        status_next    = STAT_RAN;
                        ran_id_next    = head_dec.id;
                        finished_next  = head_done;
                        remaining_next = head_dec.remaining;
                        prio_out_next  = head_dec.prio;
                        cmd.op         = OP_POP;
                        hold_load      = !head_done;
                    end
                end
            end
            ST_REINSERT:
            begin
                cmd.op        = OP_INSERT;
                cmd.new_entry = hold_reg;
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload and process held for reinsertion
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            status_reg    <= status_next;
            ran_id_reg    <= ran_id_next;
            finished_reg  <= finished_next;
            remaining_reg <= remaining_next;
            prio_out_reg  <= prio_out_next;
        end
        if (hold_load)
            hold_reg <= hold_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.ran_id          = ran_id_reg;
    assign rsp.finished        = finished_reg;
    assign rsp.remaining_after = remaining_reg;
    assign rsp.priority_after  = prio_out_reg;

endmodule

// ===== hw/rtl/dps_checker.sv =====
// Port-level assertions for the scheduler, bound to the top level.
module dps_checker
    import dps_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STAT_W-1:0]        status,
    input logic [ID_W-1:0]          ran_id,
    input logic                     finished,
    input logic [TIME_W-1:0]        remaining_after,
    input logic signed [PRIO_W-1:0] priority_after
);

    // Every accepted request shows a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("no result after accepted request");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= STAT_IDLE))
        else $error("undefined status code");

    // Results that ran nothing carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != STAT_RAN)) |->
        ((ran_id == '0) && !finished && (remaining_after == '0) && (priority_after == '0)))
        else $error("nonzero fields on a result that ran nothing");

    // Finished flag agrees with remaining time
    a_finished_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STAT_RAN)) |-> (finished == (remaining_after == '0)))
        else $error("finished flag disagrees with remaining time");

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(ran_id)))
        else $error("stalled result changed");

endmodule

bind dynamic_priority_scheduler_unit dps_checker u_dps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .ran_id          (rsp.ran_id),
    .finished        (rsp.finished),
    .remaining_after (rsp.remaining_after),
    .priority_after  (rsp.priority_after)
);

// ===== verif/tb_dynamic_priority_scheduler_unit.sv =====
// Testbench for the dynamic priority scheduler: directed table, random traffic, queue predictor.
module tb_dynamic_priority_scheduler_unit;
    import dps_pkg::*;

    localparam int  STALL_LIMIT  = 2000;
    localparam int  HOLD_CYCLES  = 60;
    localparam int  PHASE_ITEMS  = 300;
    localparam int  MAX_PRINTS   = 100;
    localparam bit  TYPED        = 1'b1;
    localparam bit  PREDICTED    = 1'b0;

    // One request as the sender sees it
    typedef struct packed {
        logic                     req_type;
        logic [ID_W-1:0]          proc_id;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0]        arrival_time;
        logic [TIME_W-1:0]        run_time;
    } sched_req_t;

    // One result as the receiver sees it
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ID_W-1:0]          ran_id;
        logic                     finished;
        logic [TIME_W-1:0]        remaining_after;
        logic signed [PRIO_W-1:0] priority_after;
    } sched_result_t;

    // Directed row: request, then a hand-written result where typed is set
    typedef struct packed {
        sched_req_t    rq;
        logic          typed;
        sched_result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 18;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // slice on an empty queue
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_IDLE, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        // zero run time is rejected
        '{'{REQ_ADD, 8'h11, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_ZERO_RUN, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        // top priority, one slice
        '{'{REQ_ADD, 8'hFF, 8'sd127, 16'h0000, 16'h0001}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_RAN, 8'hFF, 1'b1, 16'h0000, 8'sd126}},
        // bottom priority saturates
        '{'{REQ_ADD, 8'h00, PRIO_MIN, 16'hFFFF, 16'h0002}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_RAN, 8'h00, 1'b0, 16'h0001, PRIO_MIN}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_RAN, 8'h00, 1'b1, 16'h0000, PRIO_MIN}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_IDLE, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        // ties on priority: arrival, then insertion order
        '{'{REQ_ADD, 8'h01, 8'sd5, 16'd10, 16'd3}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_ADD, 8'h02, 8'sd5, 16'd5, 16'd2}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_ADD, 8'h03, 8'sd5, 16'd10, 16'd2}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_ADD, 8'h04, 8'sd6, 16'd20, 16'd1}, TYPED,
          '{STAT_ADDED, 8'h00, 1'b0, 16'h0000, 8'sd0}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, TYPED,
          '{STAT_RAN, 8'h04, 1'b1, 16'h0000, 8'sd5}},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, PREDICTED, '0},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, PREDICTED, '0},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, PREDICTED, '0},
        '{'{REQ_ADD, 8'h80, -8'sd1, 16'h8000, 16'd3}, PREDICTED, '0},
        '{'{REQ_SLICE, 8'h00, 8'sd0, 16'h0000, 16'h0000}, PREDICTED, '0}
    };

    logic clk;
    logic rst_n;

    dps_req_if req_ch ();
    dps_rsp_if rsp_ch ();

    dynamic_priority_scheduler_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted ready queue, head first
    entry_t        run_queue [$];
    sched_result_t pending_results [$];
    sched_result_t head_want;

    int  mismatch_cnt;
    int  result_idx;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    int  stall_cnt;
    int  hold_left;
    bit  hold_req;
    bit  hold_done;

    always #2 clk = ~clk;

    // one line per mismatch, printing capped
    task automatic log_mismatch(string msg);
        if (mismatch_cnt < MAX_PRINTS)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    // sorted insert: behind every entry with an equal or better key
    function automatic void queue_insert(entry_t e);
        int pos;
        pos = 0;
        while (pos < run_queue.size())
        begin
            if ($signed(run_queue[pos].prio) < $signed(e.prio) ||
                (run_queue[pos].prio == e.prio && run_queue[pos].arrival > e.arrival))
                break;
            pos++;
        end
        run_queue.insert(pos, e);
    endfunction

    // advance the predicted queue by one request and return its result
    function automatic sched_result_t schedule_step(sched_req_t r);
        sched_result_t res;
        entry_t        e;
        res = '0;
        if (r.req_type == REQ_ADD)
        begin
            if (r.run_time == 0)
                res.status = STAT_ZERO_RUN;
            else if (run_queue.size() >= DPS_QUEUE_DEPTH)
                res.status = STAT_FULL;
            else
            begin
                e.id        = r.proc_id;
                e.prio      = r.priority_req;
                e.arrival   = r.arrival_time;
                e.remaining = r.run_time;
                queue_insert(e);
                res.status = STAT_ADDED;
            end
        end
        else if (run_queue.size() == 0)
        begin
            res.status = STAT_IDLE;
        end
        else
        begin
            e = run_queue.pop_front();
            if (e.prio != PRIO_MIN)
                e.prio = e.prio - 8'sd1;
            if (e.remaining != 0)
                e.remaining = e.remaining - 16'd1;
            res.status          = STAT_RAN;
            res.ran_id          = e.id;
            res.finished        = (e.remaining == 0);
            res.remaining_after = e.remaining;
            res.priority_after  = e.prio;
            if (!res.finished)
                queue_insert(e);
        end
        return res;
    endfunction

    // random request; fill_bias favors adds so the queue fills, else it drains
    function automatic sched_req_t random_request(bit fill_bias);
        sched_req_t r;
        int         roll;
        r.req_type     = ($urandom_range(99) < (fill_bias ? 70 : 30)) ? REQ_ADD : REQ_SLICE;
        r.proc_id      = ID_W'($urandom_range(255));
        r.priority_req = PRIO_W'($urandom_range(1) ? $urandom_range(255)
                                                   : $urandom_range(258, 254));
        r.arrival_time = TIME_W'($urandom_range(1) ? $urandom_range(65535)
                                                   : $urandom_range(7));
        roll = $urandom_range(99);
        if (roll < 5)
            r.run_time = 16'h0000;
        else if (run_queue.size() >= DPS_QUEUE_DEPTH)
            r.run_time = TIME_W'($urandom_range(65535, 1));
        else
            r.run_time = TIME_W'($urandom_range(5, 1));
        return r;
    endfunction

    // offer one request, keep valid high across back-to-back requests
    task automatic send_request(sched_req_t r, bit typed, sched_result_t typed_want);
        sched_result_t model_res;
        if ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.proc_id      <= r.proc_id;
        req_ch.priority_req <= r.priority_req;
        req_ch.arrival_time <= r.arrival_time;
        req_ch.run_time     <= r.run_time;
        do @(posedge clk); while (!req_ch.ready);
        model_res = schedule_step(r);
        pending_results.push_back(typed ? typed_want : model_res);
    endtask

    // receiver: random stalls, plus one long hold-off on demand
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("result %0d with none expected (status %0d)",
                                       result_idx, rsp_ch.status));
            end
            else
            begin
                head_want = pending_results.pop_front();
                if (rsp_ch.status !== head_want.status)
                    log_mismatch($sformatf("result %0d status got %0d want %0d",
                                           result_idx, rsp_ch.status, head_want.status));
                if (rsp_ch.ran_id !== head_want.ran_id)
                    log_mismatch($sformatf("result %0d ran_id got %0h want %0h",
                                           result_idx, rsp_ch.ran_id, head_want.ran_id));
                if (rsp_ch.finished !== head_want.finished)
                    log_mismatch($sformatf("result %0d finished got %0b want %0b",
                                           result_idx, rsp_ch.finished, head_want.finished));
                if (rsp_ch.remaining_after !== head_want.remaining_after)
                    log_mismatch($sformatf("result %0d remaining_after got %0d want %0d",
                                           result_idx, rsp_ch.remaining_after,
                                           head_want.remaining_after));
                if (rsp_ch.priority_after !== head_want.priority_after)
                    log_mismatch($sformatf("result %0d priority_after got %0d want %0d",
                                           result_idx, rsp_ch.priority_after,
                                           head_want.priority_after));
            end
            result_idx++;
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            stall_cnt <= 0;
        end
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // stimulus
    initial
    begin
        sched_req_t    r;
        sched_result_t typed_res;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ADD;
        req_ch.proc_id      = '0;
        req_ch.priority_req = '0;
        req_ch.arrival_time = '0;
        req_ch.run_time     = '0;
        mismatch_cnt        = 0;
        result_idx          = 0;
        hold_req            = 1'b0;
        snd_idle_pct        = 20;
        rcv_idle_pct        = 83;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_request(DIR_TAB[i].rq, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // fill the queue, then add at full and zero run time at full
        while (run_queue.size() < DPS_QUEUE_DEPTH)
        begin
            r          = random_request(1'b1);
            r.req_type = REQ_ADD;
            r.run_time = TIME_W'($urandom_range(3, 1));
            send_request(r, PREDICTED, '0);
        end
        r         = '{REQ_ADD, 8'hAA, 8'sd127, 16'h0000, 16'hFFFF};
        typed_res = '{STAT_FULL, 8'h00, 1'b0, 16'h0000, 8'sd0};
        send_request(r, TYPED, typed_res);
        r         = '{REQ_ADD, 8'h55, 8'sd0, 16'h0000, 16'h0000};
        typed_res = '{STAT_ZERO_RUN, 8'h00, 1'b0, 16'h0000, 8'sd0};
        send_request(r, TYPED, typed_res);

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin snd_idle_pct = 20; rcv_idle_pct = 83; end
                1:       begin snd_idle_pct = 83; rcv_idle_pct = 20; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long receiver hold-off so the block backs up
                if (phase == 2 && i == 20)
                    hold_req = 1'b1;
                send_request(random_request(((i / 40) % 2) == 0), PREDICTED, '0);
            end
        end
        req_ch.valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_cnt == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== dynamic_priority_scheduler_unit.f =====
hw/rtl/dps_pkg.sv
hw/rtl/dps_req_if.sv
hw/rtl/dps_rsp_if.sv
hw/rtl/dps_cell.sv
hw/rtl/dynamic_priority_scheduler_unit.sv
hw/rtl/dps_checker.sv
verif/tb_dynamic_priority_scheduler_unit.sv
